// ===== design/astcps_pkg.sv =====
// astcps_pkg: constants and types for the ASTC 2D partition selector.
// Depends on nothing; used by astc_partition_select and its checker.
`default_nettype none
package astcps_pkg;

  localparam logic [31:0] HashMul  = 32'hEEDE0891;
  localparam logic [3:0]  NibMask  = 4'hF;
  localparam logic [5:0]  FormMask = 6'h3F;
  localparam int unsigned SeedBit4 = 4;

  localparam int unsigned NumStages = 5;
  localparam int unsigned NumForms  = 4;
  localparam int unsigned NumSq     = 8;

  typedef logic [9:0]  seed_t;
  typedef logic [12:0] fseed_t;
  typedef logic [4:0]  coord_t;
  typedef logic [2:0]  count_t;
  typedef logic [3:0]  sq_t;
  typedef logic [5:0]  form_t;
  typedef logic [1:0]  pidx_t;

endpackage
`default_nettype wire

// ===== design/astc_partition_select.sv =====
// astc_partition_select: ASTC 2D texel partition index, five register stages.
// Depends on astcps_pkg.
//
//   channel   signals                                         dir
//   in        in_valid_i/in_ready_o, partition_seed_i,
//             texel_x_i, texel_y_i, part_count_i,
//             small_block_i                                   in
//   out       out_valid_o/out_ready_i, partition_index_o      out
//
// One texel per cycle while the output is not stalled.
// Stages: seed fold and hash multiply, hash mix, nibble squares and shifts,
// linear forms, argmax into the output register.
// Reset clears the stage valid bits only.
// A stall on the output freezes every stage; nothing is dropped or repeated.
`default_nettype none
module astc_partition_select (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire astcps_pkg::seed_t     partition_seed_i,
  input  wire logic [3:0]            texel_x_i,
  input  wire logic [3:0]            texel_y_i,
  input  wire astcps_pkg::count_t    part_count_i,
  input  wire logic                  small_block_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output astcps_pkg::pidx_t          partition_index_o
);
  import astcps_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic                 adv;

  assign adv        = !valid_q[NumStages-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NumStages-2:0], in_valid_i};
    end
  end

  // stage 1: fold count into seed, hash multiply, double coordinates for small blocks
  fseed_t      fseed;
  logic [31:0] prod1_d, prod1_q;
  coord_t      x1_d, y1_d, x1_q, y1_q;
  logic [4:0]  seed1_q;
  count_t      cnt1_q;

  always_comb begin
    fseed   = {3'(part_count_i - 3'd1), partition_seed_i};
    prod1_d = 32'({19'd0, fseed} * HashMul);
    x1_d    = small_block_i ? {texel_x_i, 1'b0} : {1'b0, texel_x_i};
    y1_d    = small_block_i ? {texel_y_i, 1'b0} : {1'b0, texel_y_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod1_q <= prod1_d;
      seed1_q <= fseed[4:0];
      cnt1_q  <= part_count_i;
      x1_q    <= x1_d;
      y1_q    <= y1_d;
    end
  end

  // stage 2: rest of the hash mix
  logic [31:0] h2_d, h2_q;
  logic [4:0]  seed2_q;
  count_t      cnt2_q;
  coord_t      x2_q, y2_q;

  always_comb begin
    h2_d = prod1_q ^ (prod1_q >> 5);
    h2_d = h2_d + (h2_d << 16);
    h2_d = h2_d ^ (h2_d >> 7);
    h2_d = h2_d ^ (h2_d >> 3);
    h2_d = h2_d ^ (h2_d << 6);
    h2_d = h2_d ^ (h2_d >> 17);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h2_q    <= h2_d;
      seed2_q <= seed1_q;
      cnt2_q  <= cnt1_q;
      x2_q    <= x1_q;
      y2_q    <= y1_q;
    end
  end

  // stage 3: square nibbles and shift by seed- and count-dependent amounts
  logic [2:0]  sh1, sh2;
  logic [3:0]  nib;
  logic [7:0]  sqr;
  sq_t         sq3_d [NumSq];
  sq_t         sq3_q [NumSq];
  logic [17:0] hb3_q;
  count_t      cnt3_q;
  coord_t      x3_q, y3_q;

  always_comb begin
    nib = '0;
    sqr = '0;
    if (seed2_q[0]) begin
      sh1 = seed2_q[1] ? 3'd4 : 3'd5;
      sh2 = (cnt2_q == 3'd3) ? 3'd6 : 3'd5;
    end else begin
      sh1 = (cnt2_q == 3'd3) ? 3'd6 : 3'd5;
      sh2 = seed2_q[1] ? 3'd4 : 3'd5;
    end
    for (int i = 0; i < NumSq; i++) begin
      nib      = h2_q[4*i +: 4] & NibMask;
      sqr      = {4'd0, nib} * {4'd0, nib};
      sq3_d[i] = 4'(sqr >> ((i % 2 == 0) ? sh1 : sh2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq3_q  <= sq3_d;
      hb3_q  <= h2_q[19:2];
      cnt3_q <= cnt2_q;
      x3_q   <= x2_q;
      y3_q   <= y2_q;
    end
  end

  // stage 4: linear forms, masked and gated by count
  form_t f4_d [NumForms];
  form_t f4_q [NumForms];
  logic [5:0] px, py;

  always_comb begin
    px = '0;
    py = '0;
    for (int k = 0; k < NumForms; k++) begin
      px = 6'({5'd0, sq3_q[2*k]}   * {4'd0, x3_q});
      py = 6'({5'd0, sq3_q[2*k+1]} * {4'd0, y3_q});
      f4_d[k] = (px + py + hb3_q[(12 - 4*k) +: 6]) & FormMask;
    end
    if (cnt3_q <= 3'd3) f4_d[3] = '0;
    if (cnt3_q <= 3'd2) f4_d[2] = '0;
    if (cnt3_q <= 3'd1) f4_d[1] = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f4_q <= f4_d;
    end
  end

  // stage 5: argmax, ties to the lower index
  pidx_t idx5_d, idx5_q;
  form_t best;

  always_comb begin
    idx5_d = '0;
    best   = f4_q[0];
    for (int k = 1; k < NumForms; k++) begin
      if (f4_q[k] > best) begin
        best   = f4_q[k];
        idx5_d = 2'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx5_q <= idx5_d;
    end
  end

  assign out_valid_o       = valid_q[NumStages-1];
  assign partition_index_o = idx5_q;

endmodule
`default_nettype wire

// ===== design/astcps_checker.sv =====
// astcps_checker: port-level assertions for astc_partition_select, bound to it.
// Depends on astcps_pkg.
`default_nettype none
module astcps_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire astcps_pkg::pidx_t  partition_index_o
);
  import astcps_pkg::*;

  logic [2:0] pend_q, pend_d;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_beat && !out_beat) pend_d = pend_q + 3'd1;
    if (!in_beat && out_beat) pend_d = pend_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(partition_index_o))
    else $error("output beat changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("output beat without a pending input beat");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'(NumStages))
    else $error("more beats in flight than pipeline stages");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

endmodule

bind astc_partition_select astcps_checker u_astcps_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .partition_index_o (partition_index_o)
);
`default_nettype wire
